FILE: rtl/tlpt_pkg.sv
// Package: entry layout, field widths and codes shared by the page-table block.
`default_nettype none

package tlpt_pkg;

  localparam int PPN_W   = 44;
  localparam int VPN_W   = 27;
  localparam int FLAGS_W = 7;
  localparam int IDX_W   = 9;
  localparam int STAT_W  = 2;

  localparam logic KIND_MAP   = 1'b0;
  localparam logic KIND_UNMAP = 1'b1;

  localparam logic [STAT_W-1:0] ST_DONE       = 2'd0;
  localparam logic [STAT_W-1:0] ST_ALREADY    = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_MAPPED = 2'd2;
  localparam logic [STAT_W-1:0] ST_EXHAUSTED  = 2'd3;

  // Bits 63..54 of an entry are never set, so they are not stored.
  typedef struct packed {
    logic [PPN_W-1:0]   ppn;
    logic [1:0]         rsvd;
    logic [FLAGS_W-1:0] flags;
    logic               v;
  } entry_t;

endpackage

`default_nettype wire

FILE: rtl/tlpt_if.sv
// Interfaces: request and response channels of the page-table block.
`default_nettype none

interface tlpt_req_if;
  logic                            valid;
  logic                            ready;
  logic                            kind;
  logic [tlpt_pkg::VPN_W-1:0]      vpn;
  logic [tlpt_pkg::PPN_W-1:0]      ppn;
  logic [tlpt_pkg::FLAGS_W-1:0]    flags;

  modport source (output valid, kind, vpn, ppn, flags, input ready);
  modport sink   (input valid, kind, vpn, ppn, flags, output ready);
endinterface

interface tlpt_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [tlpt_pkg::STAT_W-1:0]     status;
  logic                            freed_valid;
  logic [tlpt_pkg::PPN_W-1:0]      freed_ppn;

  modport source (output valid, status, freed_valid, freed_ppn, input ready);
  modport sink   (input valid, status, freed_valid, freed_ppn, output ready);
endinterface

`default_nettype wire

FILE: rtl/tlpt_store.sv
// Table store: single-port-write, single-port-read RAM with write-to-read bypass.
`default_nettype none

module tlpt_store #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire tlpt_pkg::entry_t  wdata,
  input  wire logic [AW-1:0]     raddr,
  output tlpt_pkg::entry_t       rdata
);

  tlpt_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Return the word being written when both ports hit the same entry.
  always_ff @(posedge clk) begin
    if (we && waddr == raddr) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/three_level_page_table_map_unmap_top.sv
// Top level: three-level page-table walker that maps and unmaps pages in its own store.
//
//   channel | role   | handshake         | payload
//   --------+--------+-------------------+--------------------------------------
//   req     | sink   | valid/ready       | kind, vpn, ppn, flags
//   rsp     | source | valid/ready       | status, freed_valid, freed_ppn
//   cfg     | write  | cfg_we            | cfg_wdata = table_base_ppn
//
// A request walks from acceptance through the root, middle and leaf levels to
// its response word; the three dependent reads of the one store read port set
// that order. An early error at the root level skips the two lower levels.
// One request is in flight at a time. After reset a clearing pass writes zero
// to all TABLE_FRAMES * 512 entries (8192 at the default), with req.ready low.
// A response that is not taken holds the walker in its final state; the
// output register lets the response wait without losing it.
`default_nettype none

module three_level_page_table_map_unmap_top #(
  parameter int TABLE_FRAMES = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [tlpt_pkg::PPN_W-1:0]  cfg_wdata,
  tlpt_req_if.sink                         req,
  tlpt_rsp_if.source                       rsp
);

  localparam int IDX_W = tlpt_pkg::IDX_W;
  localparam int PPN_W = tlpt_pkg::PPN_W;
  localparam int FW    = $clog2(TABLE_FRAMES);
  localparam int NW    = $clog2(TABLE_FRAMES + 1);
  localparam int AW    = FW + IDX_W;
  localparam int DEPTH = TABLE_FRAMES * (2 ** IDX_W);

  localparam logic [AW-1:0]    CLR_LAST = AW'(DEPTH - 1);
  localparam logic [PPN_W-1:0] TF_PPN   = PPN_W'(TABLE_FRAMES);
  localparam logic [NW:0]      TF_N     = (NW + 1)'(TABLE_FRAMES);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_L2   = 3'd2;
  localparam logic [2:0] S_W1   = 3'd3;
  localparam logic [2:0] S_L1   = 3'd4;
  localparam logic [2:0] S_L0   = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  // Control registers
  logic [2:0]       state, state_next;
  logic [AW-1:0]    clr_addr;
  logic [NW-1:0]    nff, nff_next;
  logic [PPN_W-1:0] base;

  // Request held for the walk
  logic                            kind_q;
  logic [IDX_W-1:0]                i2, i1, i0;
  logic [PPN_W-1:0]                ppn_q;
  logic [tlpt_pkg::FLAGS_W-1:0]    flags_q;
  logic [FW-1:0]                   f1, f1_next, f0, f0_next;

  // Result of the walk and the output register
  logic [tlpt_pkg::STAT_W-1:0] res_status, res_status_next;
  logic                        res_freed, res_freed_next;
  logic [PPN_W-1:0]            res_ppn, res_ppn_next;
  logic                        out_valid;
  logic [tlpt_pkg::STAT_W-1:0] out_status;
  logic                        out_freed;
  logic [PPN_W-1:0]            out_ppn;

  // Store port
  logic             st_we;
  logic [AW-1:0]    st_waddr, st_raddr;
  tlpt_pkg::entry_t st_wdata, st_rdata;

  // Walk helpers
  logic [PPN_W-1:0] off;
  logic             off_hit;
  logic [FW-1:0]    alloc_frame;
  logic [PPN_W-1:0] alloc_ppn;
  tlpt_pkg::entry_t alloc_ptr;
  logic             room1, room2;
  logic             out_free;

  tlpt_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // Resolve the entry just read back to a frame of the store.
  assign off     = st_rdata.ppn - base;
  assign off_hit = off < TF_PPN;

  // Pointer to the frame being taken: the next free one, or the second of a pair.
  assign alloc_frame = (state == S_W1) ? f0 : nff[FW-1:0];
  assign alloc_ppn   = base + PPN_W'(alloc_frame);
  assign alloc_ptr   = '{ppn: alloc_ppn, rsvd: 2'b00, flags: '0, v: 1'b1};

  assign room1 = ({1'b0, nff} + (NW + 1)'(1)) <= TF_N;
  assign room2 = ({1'b0, nff} + (NW + 1)'(2)) <= TF_N;

  assign out_free = !out_valid || rsp.ready;

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.freed_valid = out_freed;
  assign rsp.freed_ppn   = out_ppn;

  always_comb begin
    state_next      = state;
    nff_next        = nff;
    f1_next         = f1;
    f0_next         = f0;
    res_status_next = res_status;
    res_freed_next  = res_freed;
    res_ppn_next    = res_ppn;
    st_we           = 1'b0;
    st_waddr        = '0;
    st_wdata        = '0;
    st_raddr        = '0;

    unique case (state)
      S_CLR: begin
        // Sweep zeros through the whole store.
        st_we    = 1'b1;
        st_waddr = clr_addr;
        if (clr_addr == CLR_LAST) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        // Read the root entry straight from the request.
        st_raddr        = {FW'(0), req.vpn[2*IDX_W +: IDX_W]};
        res_freed_next  = 1'b0;
        res_ppn_next    = '0;
        if (req.valid) begin
          state_next = S_L2;
        end
      end

      S_L2: begin
        if (st_rdata.v) begin
          if (off_hit) begin
            f1_next    = off[FW-1:0];
            st_raddr   = {off[FW-1:0], i1};
            state_next = S_L1;
          end else begin
            res_status_next = tlpt_pkg::ST_NOT_MAPPED;
            state_next      = S_DONE;
          end
        end else if (kind_q == tlpt_pkg::KIND_UNMAP) begin
          res_status_next = tlpt_pkg::ST_NOT_MAPPED;
          state_next      = S_DONE;
        end else if (!room2) begin
          res_status_next = tlpt_pkg::ST_EXHAUSTED;
          state_next      = S_DONE;
        end else begin
          // Take two frames: point the root at the first.
          st_we      = 1'b1;
          st_waddr   = {FW'(0), i2};
          st_wdata   = alloc_ptr;
          f1_next    = nff[FW-1:0];
          f0_next    = FW'(nff + NW'(1));
          nff_next   = NW'(nff + NW'(2));
          state_next = S_W1;
        end
      end

      S_W1: begin
        // Point the new middle entry at the second frame, and read the leaf in the same state.
        st_we      = 1'b1;
        st_waddr   = {f1, i1};
        st_wdata   = alloc_ptr;
        st_raddr   = {f0, i0};
        state_next = S_L0;
      end

      S_L1: begin
        if (st_rdata.v) begin
          if (off_hit) begin
            f0_next    = off[FW-1:0];
            st_raddr   = {off[FW-1:0], i0};
            state_next = S_L0;
          end else begin
            res_status_next = tlpt_pkg::ST_NOT_MAPPED;
            state_next      = S_DONE;
          end
        end else if (kind_q == tlpt_pkg::KIND_UNMAP) begin
          res_status_next = tlpt_pkg::ST_NOT_MAPPED;
          state_next      = S_DONE;
        end else if (!room1) begin
          res_status_next = tlpt_pkg::ST_EXHAUSTED;
          state_next      = S_DONE;
        end else begin
          // Take one frame; the bypass covers a leaf read of the same entry.
          st_we      = 1'b1;
          st_waddr   = {f1, i1};
          st_wdata   = alloc_ptr;
          st_raddr   = {nff[FW-1:0], i0};
          f0_next    = nff[FW-1:0];
          nff_next   = NW'(nff + NW'(1));
          state_next = S_L0;
        end
      end

      S_L0: begin
        state_next = S_DONE;
        if (kind_q == tlpt_pkg::KIND_MAP) begin
          if (st_rdata.v) begin
            res_status_next = tlpt_pkg::ST_ALREADY;
          end else begin
            st_we           = 1'b1;
            st_waddr        = {f0, i0};
            st_wdata        = '{ppn: ppn_q, rsvd: 2'b00, flags: flags_q, v: 1'b1};
            res_status_next = tlpt_pkg::ST_DONE;
          end
        end else if (st_rdata.v) begin
          // Drop the leaf and report its page.
          st_we           = 1'b1;
          st_waddr        = {f0, i0};
          res_status_next = tlpt_pkg::ST_DONE;
          res_freed_next  = 1'b1;
          res_ppn_next    = st_rdata.ppn;
        end else begin
          res_status_next = tlpt_pkg::ST_NOT_MAPPED;
        end
      end

      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_addr  <= '0;
      nff       <= NW'(1);
      base      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      nff   <= nff_next;
      if (state == S_CLR) begin
        clr_addr <= AW'(clr_addr + AW'(1));
      end
      if (cfg_we) begin
        base <= cfg_wdata;
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    f1         <= f1_next;
    f0         <= f0_next;
    res_status <= res_status_next;
    res_freed  <= res_freed_next;
    res_ppn    <= res_ppn_next;
    if (req.valid && req.ready) begin
      kind_q  <= req.kind;
      i2      <= req.vpn[2*IDX_W +: IDX_W];
      i1      <= req.vpn[IDX_W +: IDX_W];
      i0      <= req.vpn[0 +: IDX_W];
      ppn_q   <= req.ppn;
      flags_q <= req.flags;
    end
    if (state == S_DONE && out_free) begin
      out_status <= res_status;
      out_freed  <= res_freed;
      out_ppn    <= res_ppn;
    end
  end

  // Checks on the walker

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !st_we)
    else $error("store written while walker idle");

  a_frames_bounded: assert property (@(posedge clk) disable iff (rst)
    {1'b0, nff} <= TF_N)
    else $error("free frame index beyond store");

  a_freed_done: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.freed_valid |-> rsp.status == tlpt_pkg::ST_DONE)
    else $error("freed page reported with failing status");

  a_accept_walks: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state == S_L2)
    else $error("accepted request did not start a walk");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking bench for the page-table walker: directed script, then random map/unmap words.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tlpt_pkg::*;

  localparam int FRAMES      = 16;
  localparam int ENTRIES     = 512;
  localparam int CYCLE_LIMIT = 300000;
  localparam int TAIL_CYCLES = 20;

  // One request word and one response word, at the block's own widths.
  typedef struct packed {
    logic               kind;
    logic [VPN_W-1:0]   vpn;
    logic [PPN_W-1:0]   ppn;
    logic [FLAGS_W-1:0] flags;
  } pt_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              freed_valid;
    logic [PPN_W-1:0]  freed_ppn;
  } pt_rsp_t;

  typedef struct {
    pt_req_t cause;
    pt_rsp_t want;
  } owed_t;

  // A script row either writes the base register or sends one request word.
  typedef enum logic {ROW_REQ, ROW_CFG} row_op_t;

  typedef struct {
    row_op_t op;
    pt_req_t rq;
    logic    known;
    pt_rsp_t want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [PPN_W-1:0] cfg_wdata;

  tlpt_req_if req_ch ();
  tlpt_rsp_if rsp_ch ();

  three_level_page_table_map_unmap_top #(
    .TABLE_FRAMES (FRAMES)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // 10 ns clock, high then low.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the table store, the frame allocator and the base register.
  logic [63:0]      shadow_store [0:FRAMES*ENTRIES-1];
  int               shadow_next_frame;
  logic [PPN_W-1:0] shadow_base;

  owed_t       awaited_outcomes [$];
  script_row_t script [$];

  int gap_pct;     // chance of a sender gap before a word
  int stall_pct;   // chance of a receiver stall at a given cycle
  int bad_words;
  int cycle_count;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Frame that an upper entry points at, or -1 when the page lies outside
  // the store under the current base.
  function automatic int frame_of(logic [63:0] e);
    logic [PPN_W-1:0] off;
    off = e[PPN_W+9:10] - shadow_base;
    if (off >= PPN_W'(FRAMES)) return -1;
    return int'(off);
  endfunction

  function automatic logic [63:0] pointer_to(int frame);
    return {10'b0, shadow_base + PPN_W'(frame), 9'b0, 1'b1};
  endfunction

  // Walk the shadow table for one request, apply its effect and return the
  // response word it must produce.
  function automatic pt_rsp_t page_table_outcome(pt_req_t r);
    logic [IDX_W-1:0] i2, i1, i0;
    int f1, f0, need, leaf;
    pt_rsp_t o;
    o    = '0;
    i2   = r.vpn[3*IDX_W-1:2*IDX_W];
    i1   = r.vpn[2*IDX_W-1:IDX_W];
    i0   = r.vpn[IDX_W-1:0];
    f1   = -1;
    f0   = -1;
    need = 0;
    o.status = ST_NOT_MAPPED;

    if (r.kind == KIND_MAP) begin
      if (shadow_store[int'(i2)][0]) begin
        f1 = frame_of(shadow_store[int'(i2)]);
        if (f1 < 0) return o;
        if (shadow_store[f1*ENTRIES + int'(i1)][0]) begin
          f0 = frame_of(shadow_store[f1*ENTRIES + int'(i1)]);
          if (f0 < 0) return o;
        end else begin
          need = 1;
        end
      end else begin
        need = 2;
      end
      // All or nothing: a map that cannot get every frame it needs leaves
      // the table alone.
      if (need > FRAMES - shadow_next_frame) begin
        o.status = ST_EXHAUSTED;
        return o;
      end
      if (need == 2) begin
        f1 = shadow_next_frame;
        shadow_next_frame++;
        shadow_store[int'(i2)] = pointer_to(f1);
      end
      if (need >= 1) begin
        f0 = shadow_next_frame;
        shadow_next_frame++;
        shadow_store[f1*ENTRIES + int'(i1)] = pointer_to(f0);
      end
      leaf = f0*ENTRIES + int'(i0);
      if (shadow_store[leaf][0]) begin
        o.status = ST_ALREADY;
      end else begin
        shadow_store[leaf] = {10'b0, r.ppn, 2'b0, r.flags, 1'b1};
        o.status = ST_DONE;
      end
    end else begin
      if (!shadow_store[int'(i2)][0]) return o;
      f1 = frame_of(shadow_store[int'(i2)]);
      if (f1 < 0) return o;
      if (!shadow_store[f1*ENTRIES + int'(i1)][0]) return o;
      f0 = frame_of(shadow_store[f1*ENTRIES + int'(i1)]);
      if (f0 < 0) return o;
      leaf = f0*ENTRIES + int'(i0);
      if (!shadow_store[leaf][0]) return o;
      // Only the leaf goes; upper entries stay for their other mappings.
      o.status      = ST_DONE;
      o.freed_valid = 1'b1;
      o.freed_ppn   = shadow_store[leaf][PPN_W+9:10];
      shadow_store[leaf] = '0;
    end
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed script
  // ---------------------------------------------------------------------------

  function automatic void add_row(row_op_t op, logic kind, logic [VPN_W-1:0] vpn,
                                  logic [PPN_W-1:0] ppn, logic [FLAGS_W-1:0] flags,
                                  logic known, logic [STAT_W-1:0] st,
                                  logic fv, logic [PPN_W-1:0] fp);
    script_row_t s;
    s.op             = op;
    s.rq.kind        = kind;
    s.rq.vpn         = vpn;
    s.rq.ppn         = ppn;
    s.rq.flags       = flags;
    s.known          = known;
    s.want.status    = st;
    s.want.freed_valid = fv;
    s.want.freed_ppn = fp;
    script.push_back(s);
  endfunction

  function automatic void build_script();
    logic [PPN_W-1:0] pmax;
    logic [VPN_W-1:0] vmax;
    pmax = '1;
    vmax = '1;
    // Empty table: nothing to unmap.
    add_row(ROW_REQ, KIND_UNMAP, '0, '0, '0, 1'b1, ST_NOT_MAPPED, 1'b0, '0);
    // First map builds both upper levels; a repeat is refused as already mapped.
    add_row(ROW_REQ, KIND_MAP, '0, pmax, '1, 1'b1, ST_DONE, 1'b0, '0);
    add_row(ROW_REQ, KIND_MAP, '0, '0, '0, 1'b1, ST_ALREADY, 1'b0, '0);
    add_row(ROW_REQ, KIND_UNMAP, '0, '0, '0, 1'b1, ST_DONE, 1'b1, pmax);
    add_row(ROW_REQ, KIND_UNMAP, '0, '0, '0, 1'b1, ST_NOT_MAPPED, 1'b0, '0);
    // Tables remain after unmap, so a new leaf needs no frame.
    add_row(ROW_REQ, KIND_MAP, '0, 44'h123456789AB, 7'h2A, 1'b1, ST_DONE, 1'b0, '0);
    add_row(ROW_REQ, KIND_MAP, vmax, '0, '0, 1'b1, ST_DONE, 1'b0, '0);
    add_row(ROW_REQ, KIND_MAP, 27'h00001FF, 44'hAAAAAAAAAAA, 7'h55, 1'b1, ST_DONE, 1'b0, '0);
    // Middle entry missing, then leaf missing.
    add_row(ROW_REQ, KIND_UNMAP, 27'h0000200, '0, '0, 1'b1, ST_NOT_MAPPED, 1'b0, '0);
    add_row(ROW_REQ, KIND_UNMAP, 27'h0000005, '0, '0, 1'b1, ST_NOT_MAPPED, 1'b0, '0);
    add_row(ROW_REQ, KIND_MAP, 27'h0000200, 44'h55555555555, 7'h2A, 1'b1, ST_DONE, 1'b0, '0);
    add_row(ROW_REQ, KIND_MAP, 27'h5555555, 44'hFEDCBA98765, 7'h01, 1'b0, '0, 1'b0, '0);
    add_row(ROW_REQ, KIND_UNMAP, vmax, pmax, '1, 1'b1, ST_DONE, 1'b1, '0);
    add_row(ROW_REQ, KIND_UNMAP, 27'h00001FF, '0, '0, 1'b1, ST_DONE, 1'b1, 44'hAAAAAAAAAAA);
    // Move the base so every stored pointer falls outside the store.
    add_row(ROW_CFG, KIND_MAP, '0, 44'd20, '0, 1'b0, '0, 1'b0, '0);
    add_row(ROW_REQ, KIND_UNMAP, 27'h0000200, '0, '0, 1'b1, ST_NOT_MAPPED, 1'b0, '0);
    add_row(ROW_REQ, KIND_MAP, 27'h5555555, '1, '1, 1'b1, ST_NOT_MAPPED, 1'b0, '0);
    // Back to zero: the old tree is reachable again.
    add_row(ROW_CFG, KIND_MAP, '0, '0, '0, 1'b0, '0, 1'b0, '0);
    add_row(ROW_REQ, KIND_MAP, 27'h0000200, '0, '0, 1'b1, ST_ALREADY, 1'b0, '0);
    add_row(ROW_REQ, KIND_UNMAP, 27'h5555555, '0, '0, 1'b0, '0, 1'b0, '0);
    add_row(ROW_REQ, KIND_UNMAP, '0, '0, '0, 1'b1, ST_DONE, 1'b1, 44'h123456789AB);
  endfunction

  // ---------------------------------------------------------------------------
  // Random words
  // ---------------------------------------------------------------------------

  // Upper-level index from a small set, so maps and unmaps meet on the
  // same tables instead of burning the few frames there are.
  function automatic logic [IDX_W-1:0] busy_index();
    case ($urandom_range(0, 2))
      0: return '0;
      1: return '1;
      default: return 9'h155;
    endcase
  endfunction

  function automatic pt_req_t random_request(int fresh_pct);
    pt_req_t r;
    logic [63:0] wide;
    logic [IDX_W-1:0] i0;
    r.kind  = ($urandom_range(1, 100) <= 55) ? KIND_MAP : KIND_UNMAP;
    wide    = {$urandom, $urandom};
    r.ppn   = wide[PPN_W-1:0];
    r.flags = FLAGS_W'($urandom_range(0, 127));
    if ($urandom_range(1, 100) <= fresh_pct) begin
      wide  = {$urandom, $urandom};
      r.vpn = wide[VPN_W-1:0];
    end else begin
      // Leaf index near either end of the table, so leaves get reused.
      i0 = IDX_W'($urandom_range(0, 7));
      if ($urandom_range(0, 1) == 1) i0 = i0 | 9'h1F8;
      r.vpn = {busy_index(), busy_index(), i0};
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one request word from a falling edge, hold it until taken, then
  // queue the response it must produce.
  task automatic issue(input pt_req_t r, input logic known, input pt_rsp_t typed);
    owed_t o;
    pt_rsp_t predicted;
    @(negedge clk);
    if ($urandom_range(1, 100) <= gap_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind  <= r.kind;
    req_ch.vpn   <= r.vpn;
    req_ch.ppn   <= r.ppn;
    req_ch.flags <= r.flags;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    // Step the shadow in any case; a typed row only overrides the answer.
    predicted = page_table_outcome(r);
    o.cause   = r;
    o.want    = known ? typed : predicted;
    awaited_outcomes.push_back(o);
  endtask

  // Drain every outstanding response, then write the base register.
  task automatic write_base(input logic [PPN_W-1:0] v);
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (awaited_outcomes.size() != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we      <= 1'b0;
    shadow_base = v;
  endtask

  task automatic random_run(input int count, input int fresh_pct);
    pt_rsp_t none;
    none = '0;
    repeat (count) issue(random_request(fresh_pct), 1'b0, none);
  endtask

  // ---------------------------------------------------------------------------
  // Response side: stall in bursts, check every word taken
  // ---------------------------------------------------------------------------

  initial begin : rsp_taker
    int hold;
    hold = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        rsp_ch.ready <= 1'b0;
      end else if ($urandom_range(1, 100) <= stall_pct) begin
        hold = $urandom_range(1, 10) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  function automatic void note_bad(string what, owed_t o, pt_rsp_t got);
    bad_words++;
    if (bad_words <= 10)
      $display("%t %s: kind %0d vpn %h: want st %0d fv %0b fp %h, got st %0d fv %0b fp %h",
               $realtime, what, o.cause.kind, o.cause.vpn, o.want.status,
               o.want.freed_valid, o.want.freed_ppn, got.status, got.freed_valid,
               got.freed_ppn);
  endfunction

  always @(posedge clk) begin : rsp_check
    pt_rsp_t got;
    owed_t o;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.status      = rsp_ch.status;
      got.freed_valid = rsp_ch.freed_valid;
      got.freed_ppn   = rsp_ch.freed_ppn;
      if (awaited_outcomes.size() == 0) begin
        o.cause = '0;
        o.want  = '0;
        note_bad("response word with nothing owed", o, got);
      end else begin
        o = awaited_outcomes.pop_front();
        if (got.status !== o.want.status || got.freed_valid !== o.want.freed_valid ||
            got.freed_ppn !== o.want.freed_ppn)
          note_bad("response word differs", o, got);
      end
    end
  end

  // Watchdog: give up well beyond the slowest legal run.
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    logic [63:0] wide;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    req_ch.valid = 1'b0;
    req_ch.kind  = KIND_MAP;
    req_ch.vpn   = '0;
    req_ch.ppn   = '0;
    req_ch.flags = '0;
    bad_words    = 0;
    cycle_count  = 0;
    gap_pct      = 30;
    stall_pct    = 30;

    foreach (shadow_store[k]) shadow_store[k] = '0;
    shadow_next_frame = 1;
    shadow_base       = '0;
    build_script();

    // Hold reset, then drop it on a falling edge. The block
    // then clears its store with ready low; the first word just waits.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed script.
    foreach (script[k]) begin
      if (script[k].op == ROW_CFG) write_base(script[k].rq.ppn);
      else issue(script[k].rq, script[k].known, script[k].want);
    end

    // Mostly work on the busy tables, with a few fresh addresses that keep
    // taking frames until the store runs dry.
    gap_pct   = 20;
    stall_pct = 20;
    random_run(300, 5);

    // Top base value: stored pointers now land one frame further on, and
    // the highest frame drops out of the store.
    gap_pct   = 0;
    stall_pct = 0;
    write_base('1);
    random_run(150, 10);

    // Arbitrary base: nearly every pointer is out of range.
    gap_pct   = 40;
    stall_pct = 40;
    wide      = {$urandom, $urandom};
    write_base(wide[PPN_W-1:0]);
    random_run(150, 20);

    // Zero base again, flat out with no idling to the end.
    gap_pct   = 0;
    stall_pct = 0;
    write_base('0);
    random_run(200, 5);

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
    // Let any stray word show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);

    if (bad_words == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/tlpt_pkg.sv
rtl/tlpt_if.sv
rtl/tlpt_store.sv
rtl/three_level_page_table_map_unmap_top.sv
tb/tb_top.sv
